>>> rtl/sfcb_pkg.sv
// ----------------------------------------------------------------------------
// sfcb_pkg
// types and constants shared by the shannon-fano code builder
// ----------------------------------------------------------------------------
package sfcb_pkg;

  localparam int MaxSymbols = 16;
  localparam int IdxBits    = 4;
  localparam int CntBits    = 5;
  localparam int WeightBits = 16;
  localparam int CodeBits   = 15;
  localparam int LenBits    = 4;
  localparam int SumBits    = WeightBits + IdxBits + 1;

  localparam logic [LenBits-1:0] LenMax = LenBits'(CodeBits);

  typedef struct packed {
    logic [WeightBits-1:0] weight;
    logic                  last;
  } in_req_t;

  typedef struct packed {
    logic [IdxBits-1:0]    symbol_index;
    logic [WeightBits-1:0] symbol_weight;
    logic [CodeBits-1:0]   code_bits;
    logic [LenBits-1:0]    code_length;
    logic                  dropped;
    logic                  final_res;
  } out_req_t;

  typedef struct packed {
    logic [WeightBits-1:0] weight;
    logic [IdxBits-1:0]    index;
  } sym_t;

  typedef struct packed {
    logic [CodeBits-1:0] code;
    logic [LenBits-1:0]  len;
  } code_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_I,
    ST_SORT_LI,
    ST_SORT_CMP,
    ST_SORT_WI,
    ST_SEG,
    ST_SUM,
    ST_WALK,
    ST_BITS_RD,
    ST_BITS_WR,
    ST_PUSH_HI,
    ST_PUSH_LO,
    ST_POP,
    ST_POP_D,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/sfcb_ram.sv
// ----------------------------------------------------------------------------
// sfcb_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module sfcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/shannon_fano_code_builder.sv
// ----------------------------------------------------------------------------
// shannon_fano_code_builder
// loads symbol weights, sorts them, splits segments and emits one code each
// ----------------------------------------------------------------------------
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_data  (sfcb_pkg::in_req_t)
// out     | out_valid | out_stall | out_data (sfcb_pkg::out_req_t)
//
// a request without last is taken at once; a last request starts the build
// sort: one row per index i, each row ending in a write back to position i
// segment l..h: sums, walk steps toward the split, bits into the codes,
// stack push and pop; then the final pop and the codes out one by one
// reset clears count, overflow flag and control registers; memories are not cleared
// in_stall is high from a last request until the final code is taken
// ----------------------------------------------------------------------------
module shannon_fano_code_builder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sfcb_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sfcb_pkg::out_req_t out_data
);

  localparam int IB = sfcb_pkg::IdxBits;
  localparam int CB = sfcb_pkg::CntBits;
  localparam int SB = sfcb_pkg::SumBits;

  sfcb_pkg::state_t state, state_next;

  logic [CB-1:0]  count;
  logic           ovf;
  logic [IB-1:0]  i, j, p, l, h, k, m;
  logic [IB:0]    sp;
  logic [SB-1:0]  total, s1, best;
  logic           first;
  sfcb_pkg::sym_t cur;

  // symbol memory
  logic              s_we;
  logic [IB-1:0]     s_wa, s_ra;
  sfcb_pkg::sym_t    s_wd, s_da;
  // code memory
  logic              c_we;
  logic [IB-1:0]     c_wa, c_ra;
  sfcb_pkg::code_t   c_wd, c_da;
  // segment stack
  logic              g_we;
  logic [IB-1:0]     g_wa, g_ra;
  logic [2*IB-1:0]   g_wd, g_da;

  sfcb_ram #(.Width($bits(sfcb_pkg::sym_t)), .Depth(sfcb_pkg::MaxSymbols)) u_sym (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_da));
  sfcb_ram #(.Width($bits(sfcb_pkg::code_t)), .Depth(sfcb_pkg::MaxSymbols)) u_code (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_da));
  sfcb_ram #(.Width(2*IB), .Depth(sfcb_pkg::MaxSymbols)) u_stack (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_da));

  logic [SB-1:0] s1_cur, s1_new, s2_new, d_new;
  logic [IB-1:0] nlast, lp1, kp1;
  logic          in_acc, out_acc, room, walk_stop, walk_end;

  assign nlast   = IB'(count - CB'(1));
  assign lp1     = l + IB'(1);
  assign kp1     = k + IB'(1);
  assign room    = (count < CB'(sfcb_pkg::MaxSymbols));
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (state != sfcb_pkg::ST_LOAD);
  assign out_valid = (state == sfcb_pkg::ST_EMIT);

  // walk: s1 holds sum(l..m), split below m moves weight m across
  assign s1_cur    = first ? total : s1;
  assign s1_new    = s1_cur - SB'(s_da.weight);
  assign s2_new    = total - s1_new;
  assign d_new     = (s1_new >= s2_new) ? s1_new - s2_new : s2_new - s1_new;
  assign walk_stop = !first && (d_new >= best);
  assign walk_end  = walk_stop || (m == lp1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfcb_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_we = 1'b0; s_wa = j; s_wd = cur; s_ra = i;
    c_we = 1'b0; c_wa = p; c_wd = c_da; c_ra = p;
    g_we = 1'b0; g_wa = IB'(sp); g_wd = '0; g_ra = IB'(sp - 1'b1);
    unique case (state)
      sfcb_pkg::ST_LOAD: begin
        if (in_acc && room) begin
          s_we = 1'b1; s_wa = IB'(count);
          s_wd = '{weight: in_data.weight, index: IB'(count)};
          c_we = 1'b1; c_wa = IB'(count); c_wd = '0;
        end
        if (in_acc && in_data.last) state_next = sfcb_pkg::ST_SORT_I;
      end
      sfcb_pkg::ST_SORT_I: state_next = sfcb_pkg::ST_SORT_LI;
      sfcb_pkg::ST_SORT_LI: state_next = sfcb_pkg::ST_SORT_CMP;
      sfcb_pkg::ST_SORT_CMP: begin
        s_ra = j + 1'b1;
        if (s_da.weight > cur.weight) begin
          s_we = 1'b1; s_wa = j; s_wd = cur;
        end
        if (j == nlast) state_next = sfcb_pkg::ST_SORT_WI;
      end
      sfcb_pkg::ST_SORT_WI: begin
        s_we = 1'b1; s_wa = i; s_wd = cur;
        if (i == nlast) begin
          state_next = (count >= CB'(2)) ? sfcb_pkg::ST_SEG : sfcb_pkg::ST_EMIT_RD;
        end else begin
          state_next = sfcb_pkg::ST_SORT_I;
        end
      end
      sfcb_pkg::ST_SEG: begin
        s_ra = l;
        state_next = sfcb_pkg::ST_SUM;
      end
      sfcb_pkg::ST_SUM: begin
        s_ra = (p == h) ? h : p + 1'b1;
        if (p == h) state_next = sfcb_pkg::ST_WALK;
      end
      sfcb_pkg::ST_WALK: begin
        s_ra = m - 1'b1;
        if (walk_end) state_next = sfcb_pkg::ST_BITS_RD;
      end
      sfcb_pkg::ST_BITS_RD: state_next = sfcb_pkg::ST_BITS_WR;
      sfcb_pkg::ST_BITS_WR: begin
        c_we = 1'b1;
        if (c_da.len < sfcb_pkg::LenMax) begin
          c_wd.code = {c_da.code[sfcb_pkg::CodeBits-2:0], (p > k)};
          c_wd.len  = c_da.len + 1'b1;
        end
        state_next = (p == h) ? sfcb_pkg::ST_PUSH_HI : sfcb_pkg::ST_BITS_RD;
      end
      sfcb_pkg::ST_PUSH_HI: begin
        if (kp1 < h) begin
          g_we = 1'b1; g_wd = {kp1, h};
        end
        state_next = sfcb_pkg::ST_PUSH_LO;
      end
      sfcb_pkg::ST_PUSH_LO: begin
        if (l < k) begin
          g_we = 1'b1; g_wd = {l, k};
        end
        state_next = sfcb_pkg::ST_POP;
      end
      sfcb_pkg::ST_POP: begin
        state_next = (sp == '0) ? sfcb_pkg::ST_EMIT_RD : sfcb_pkg::ST_POP_D;
      end
      sfcb_pkg::ST_POP_D: state_next = sfcb_pkg::ST_SEG;
      sfcb_pkg::ST_EMIT_RD: begin
        s_ra = p;
        state_next = sfcb_pkg::ST_EMIT;
      end
      sfcb_pkg::ST_EMIT: begin
        s_ra = p;
        if (out_acc) begin
          state_next = (p == nlast) ? sfcb_pkg::ST_LOAD : sfcb_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = sfcb_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      sp    <= '0;
      i     <= '0;
      j     <= '0;
      p     <= '0;
      l     <= '0;
      h     <= '0;
      k     <= '0;
      m     <= '0;
      total <= '0;
      s1    <= '0;
      best  <= '0;
      first <= 1'b0;
      cur   <= '0;
    end else begin
      case (state)
        sfcb_pkg::ST_LOAD: begin
          if (in_acc) begin
            if (room) count <= count + 1'b1;
            else ovf <= 1'b1;
            if (in_data.last) i <= '0;
          end
        end
        sfcb_pkg::ST_SORT_LI: begin
          cur <= s_da;
          j   <= i;
        end
        sfcb_pkg::ST_SORT_CMP: begin
          if (s_da.weight > cur.weight) cur <= s_da;
          j <= j + 1'b1;
        end
        sfcb_pkg::ST_SORT_WI: begin
          if (i == nlast) begin
            l  <= '0;
            h  <= nlast;
            p  <= '0;
            sp <= '0;
          end else begin
            i <= i + 1'b1;
          end
        end
        sfcb_pkg::ST_SEG: begin
          p     <= l;
          total <= '0;
        end
        sfcb_pkg::ST_SUM: begin
          total <= total + SB'(s_da.weight);
          if (p == h) begin
            m     <= h;
            first <= 1'b1;
          end else begin
            p <= p + 1'b1;
          end
        end
        sfcb_pkg::ST_WALK: begin
          first <= 1'b0;
          s1    <= s1_new;
          best  <= d_new;
          if (walk_stop) begin
            k <= m;
            p <= l;
          end else if (m == lp1) begin
            k <= l;
            p <= l;
          end else begin
            m <= m - 1'b1;
          end
        end
        sfcb_pkg::ST_BITS_WR: begin
          if (p != h) p <= p + 1'b1;
        end
        sfcb_pkg::ST_PUSH_HI: begin
          if (kp1 < h) sp <= sp + 1'b1;
        end
        sfcb_pkg::ST_PUSH_LO: begin
          if (l < k) sp <= sp + 1'b1;
        end
        sfcb_pkg::ST_POP: begin
          if (sp != '0) sp <= sp - 1'b1;
          else p <= '0;
        end
        sfcb_pkg::ST_POP_D: begin
          l <= g_da[2*IB-1:IB];
          h <= g_da[IB-1:0];
        end
        sfcb_pkg::ST_EMIT: begin
          if (out_acc) begin
            if (p == nlast) begin
              count <= '0;
              ovf   <= 1'b0;
            end else begin
              p <= p + 1'b1;
            end
          end
        end
        default: begin end
      endcase
    end
  end

  assign out_data.symbol_index  = s_da.index;
  assign out_data.symbol_weight = s_da.weight;
  assign out_data.code_bits     = c_da.code;
  assign out_data.code_length   = c_da.len;
  assign out_data.dropped       = ovf;
  assign out_data.final_res     = (p == nlast);

endmodule
